// File: hw/rtl/mmld_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmld_pkg
// shared widths, register codes and types of the max-log psk llr demapper
// ----------------------------------------------------------------------------
package mmld_pkg;

   localparam int SAMPLE_W      = 16;
   localparam int DIFF_W        = 17;
   localparam int DIST_W        = 33;
   localparam int LLR_W         = 20;
   localparam int INV_W         = 16;
   localparam int BPS_W         = 2;
   localparam int PAIR_W        = 64;
   localparam int NUM_PAIRS     = 4;
   localparam int CSR_IDX_W     = 3;
   localparam int MAX_POINTS_DEF = 8;
   localparam int MAX_BITS_DEF  = 3;
   localparam int QUEUE_DEPTH   = 8;
   localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

   localparam logic [BPS_W-1:0] BPS_RESET = BPS_W'(2);
   localparam logic [INV_W-1:0] INV_RESET = INV_W'(256);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BITS_PER_SYMBOL = 3'd0,
      CSR_INV_NOISE       = 3'd1,
      CSR_POINT_PAIR_0    = 3'd2,
      CSR_POINT_PAIR_1    = 3'd3,
      CSR_POINT_PAIR_2    = 3'd4,
      CSR_POINT_PAIR_3    = 3'd5
   } csr_index_type;

   typedef logic [NUM_PAIRS-1:0][PAIR_W-1:0] pair_array_type;

   typedef struct packed {
      logic              empty;
      logic              full;
      logic [QCNT_W-1:0] count;
   } queue_status_type;

endpackage

// File: hw/rtl/mmld_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmld_queue
// small first-in first-out buffer of register entries
// ----------------------------------------------------------------------------
module mmld_queue #(
   parameter int WIDTH = 8
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  logic [WIDTH-1:0]           push_data,
   input  logic                       pop,
   output logic [WIDTH-1:0]           pop_data,
   output mmld_pkg::queue_status_type status
);
   import mmld_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);

   logic [WIDTH-1:0]  mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_push, do_pop;

   assign do_pop  = pop && (count_ff != '0);
   assign do_push = push && (count_ff != QCNT_W'(QUEUE_DEPTH));

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data     = mem_ff[rd_ptr_ff];
   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign status.count = count_ff;

endmodule

// File: hw/rtl/mmld_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmld_front
// takes samples and forms the squared distance to every constellation point
// ----------------------------------------------------------------------------
module mmld_front #(
   parameter int MAX_POINTS = mmld_pkg::MAX_POINTS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   in_valid,
   input  logic signed [mmld_pkg::SAMPLE_W-1:0]   sample_i,
   input  logic signed [mmld_pkg::SAMPLE_W-1:0]   sample_q,
   input  logic                                   last_sample,
   input  mmld_pkg::pair_array_type               pairs,
   output logic                                   out_valid,
   output logic [MAX_POINTS*mmld_pkg::DIST_W:0]   out_item,
   output logic [1:0]                             inflight
);
   import mmld_pkg::*;

   logic signed [DIFF_W-1:0] di_ff [MAX_POINTS];
   logic signed [DIFF_W-1:0] dq_ff [MAX_POINTS];
   logic signed [DIFF_W-1:0] di_in [MAX_POINTS];
   logic signed [DIFF_W-1:0] dq_in [MAX_POINTS];
   logic [DIST_W-1:0]        dist_ff [MAX_POINTS];
   logic [DIST_W-1:0]        dist_in [MAX_POINTS];
   logic                     v1_ff, v2_ff;
   logic                     last1_ff, last2_ff;

   for (genvar g = 0; g < MAX_POINTS; g++) begin : g_point
      localparam int PAIR = g / 2;
      localparam int SH   = (g % 2) * 32;
      logic signed [SAMPLE_W-1:0] pt_i, pt_q;
      logic signed [2*DIFF_W-1:0] sq_i, sq_q;
      assign pt_i = $signed(pairs[PAIR][SH +: SAMPLE_W]);
      assign pt_q = $signed(pairs[PAIR][SH + SAMPLE_W +: SAMPLE_W]);
      assign di_in[g] = DIFF_W'(sample_i) - DIFF_W'(pt_i);
      assign dq_in[g] = DIFF_W'(sample_q) - DIFF_W'(pt_q);
      assign sq_i = di_ff[g] * di_ff[g];
      assign sq_q = dq_ff[g] * dq_ff[g];
      assign dist_in[g] = DIST_W'(sq_i[DIST_W-2:0]) + DIST_W'(sq_q[DIST_W-2:0]);
      assign out_item[g*DIST_W +: DIST_W] = dist_ff[g];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      last1_ff <= last_sample;
      last2_ff <= last1_ff;
      for (int g = 0; g < MAX_POINTS; g++) begin
         di_ff[g]   <= di_in[g];
         dq_ff[g]   <= dq_in[g];
         dist_ff[g] <= dist_in[g];
      end
   end

   assign out_item[MAX_POINTS*DIST_W] = last2_ff;
   assign out_valid = v2_ff;
   assign inflight  = {v1_ff & v2_ff, v1_ff ^ v2_ff};

endmodule

// File: hw/rtl/mmld_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmld_back
// per-bit minimum search, noise scaling, rounding and saturation
// ----------------------------------------------------------------------------
module mmld_back #(
   parameter int MAX_POINTS = mmld_pkg::MAX_POINTS_DEF,
   parameter int MAX_BITS   = mmld_pkg::MAX_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  in_valid,
   input  logic [MAX_POINTS*mmld_pkg::DIST_W:0]  in_item,
   input  logic [mmld_pkg::BPS_W-1:0]            bits_per_symbol,
   input  logic [mmld_pkg::INV_W-1:0]            inv_noise,
   output logic                                  out_valid,
   output logic [3*mmld_pkg::LLR_W:0]            out_item,
   output logic [1:0]                            inflight
);
   import mmld_pkg::*;

   localparam int DD_W  = DIST_W + 1;
   localparam int PR_W  = DD_W + INV_W + 1;
   localparam int RND_W = PR_W - 28 + 1;

   logic [BPS_W-1:0]           nb;
   logic signed [DD_W-1:0]     diff_in [MAX_BITS];
   logic                       en_in   [MAX_BITS];
   logic signed [DD_W-1:0]     diff_ff [MAX_BITS];
   logic                       en1_ff  [MAX_BITS];
   logic signed [PR_W-1:0]     prod_ff [MAX_BITS];
   logic                       en2_ff  [MAX_BITS];
   logic signed [LLR_W-1:0]    llr     [3];
   logic                       v1_ff, v2_ff, last1_ff, last2_ff;

   assign nb = (32'(bits_per_symbol) > MAX_BITS) ? BPS_W'(MAX_BITS) : bits_per_symbol;

   always_comb begin
      logic [DIST_W-1:0] d, m0, m1;
      logic              f0, f1;
      for (int b = 0; b < MAX_BITS; b++) begin
         m0 = '0;
         m1 = '0;
         f0 = 1'b0;
         f1 = 1'b0;
         for (int g = 0; g < MAX_POINTS; g++) begin
            d = in_item[g*DIST_W +: DIST_W];
            if (g < (1 << nb)) begin
               if (((g >> b) & 1) != 0) begin
                  if (!f1 || d < m1) begin
                     m1 = d;
                     f1 = 1'b1;
                  end
               end else begin
                  if (!f0 || d < m0) begin
                     m0 = d;
                     f0 = 1'b1;
                  end
               end
            end
         end
         diff_in[b] = $signed(DD_W'(m1)) - $signed(DD_W'(m0));
         en_in[b]   = f0 && f1 && (b < 32'(nb));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      last1_ff <= in_item[MAX_POINTS*DIST_W];
      last2_ff <= last1_ff;
      for (int b = 0; b < MAX_BITS; b++) begin
         diff_ff[b] <= diff_in[b];
         en1_ff[b]  <= en_in[b];
         prod_ff[b] <= PR_W'(diff_ff[b]) * $signed({1'b0, inv_noise});
         en2_ff[b]  <= en1_ff[b];
      end
   end

   // round half away from zero to q11.8 then saturate
   always_comb begin
      logic [PR_W-1:0]  mag;
      logic [RND_W-1:0] r;
      for (int b = 0; b < 3; b++) begin
         llr[b] = '0;
      end
      for (int b = 0; b < MAX_BITS; b++) begin
         mag = prod_ff[b][PR_W-1] ? PR_W'(-prod_ff[b]) : PR_W'(prod_ff[b]);
         r   = RND_W'((PR_W+1)'(mag + PR_W'(1 << 27)) >> 28);
         if (!en2_ff[b]) begin
            llr[b] = '0;
         end else if (prod_ff[b][PR_W-1]) begin
            llr[b] = (r > RND_W'(524288)) ? LLR_W'(-524288) : LLR_W'(-r);
         end else begin
            llr[b] = (r > RND_W'(524287)) ? LLR_W'(524287) : LLR_W'(r);
         end
      end
   end

   assign out_item  = {last2_ff, llr[2], llr[1], llr[0]};
   assign out_valid = v2_ff;
   assign inflight  = {v1_ff & v2_ff, v1_ff ^ v2_ff};

endmodule

// File: hw/rtl/mpsk_maxlog_llr_demapper_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpsk_maxlog_llr_demapper_unit
// max-log soft demapper for up to eight configured constellation points
// ----------------------------------------------------------------------------
// usage
// - samples enter as a queue push: a beat is taken when req_push is high and
//   req_full is low; one result per sample comes out in order
// - results leave as a queue pop: the oldest llr triple is on the rsp_ ports
//   while rsp_empty is low and is taken when rsp_pop is high
// - csr_ writes (always ready) set bits_per_symbol, inv_noise and the point
//   pairs; write only while the block is empty and drained
// - throughput one sample per cycle while req_full is low; from accept to
//   rsp_empty low a sample passes two distance stages, the middle queue, the
//   min and multiply stages and the output queue
// - the front (distance squares) and back (min, scale, round) stages each
//   run on credits against an eight-entry queue, so a stalled receiver fills
//   the output queue, then the middle queue, then raises req_full
// - reset clears queues and pipeline valids and loads the register defaults
// ----------------------------------------------------------------------------
module mpsk_maxlog_llr_demapper_unit #(
   parameter int MAX_POINTS = mmld_pkg::MAX_POINTS_DEF,
   parameter int MAX_BITS   = mmld_pkg::MAX_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_push,
   output logic                                 req_full,
   input  logic signed [mmld_pkg::SAMPLE_W-1:0] req_sample_i,
   input  logic signed [mmld_pkg::SAMPLE_W-1:0] req_sample_q,
   input  logic                                 req_last_sample,
   output logic                                 rsp_empty,
   input  logic                                 rsp_pop,
   output logic signed [mmld_pkg::LLR_W-1:0]    rsp_llr_bit0,
   output logic signed [mmld_pkg::LLR_W-1:0]    rsp_llr_bit1,
   output logic signed [mmld_pkg::LLR_W-1:0]    rsp_llr_bit2,
   output logic                                 rsp_last_llr,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [mmld_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [mmld_pkg::PAIR_W-1:0]          csr_data
);
   import mmld_pkg::*;

   localparam int MID_W = MAX_POINTS * DIST_W + 1;
   localparam int OUT_W = 3 * LLR_W + 1;

   // configuration registers
   logic [BPS_W-1:0] bps_ff;
   logic [INV_W-1:0] inv_ff;
   pair_array_type   pairs_ff;

   logic             accept;
   logic             front_valid, back_take, back_valid;
   logic [1:0]       front_inflight, back_inflight;
   logic [MID_W-1:0] front_item, mid_item;
   logic [OUT_W-1:0] back_item, out_item;
   queue_status_type mid_status, out_status;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         bps_ff   <= BPS_RESET;
         inv_ff   <= INV_RESET;
         pairs_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_BITS_PER_SYMBOL: bps_ff      <= csr_data[BPS_W-1:0];
            CSR_INV_NOISE:       inv_ff      <= csr_data[INV_W-1:0];
            CSR_POINT_PAIR_0:    pairs_ff[0] <= csr_data;
            CSR_POINT_PAIR_1:    pairs_ff[1] <= csr_data;
            CSR_POINT_PAIR_2:    pairs_ff[2] <= csr_data;
            CSR_POINT_PAIR_3:    pairs_ff[3] <= csr_data;
            default: ;
         endcase
      end
   end

   // front credit: items in the distance stages plus those queued
   assign req_full = (QCNT_W'(front_inflight) + mid_status.count) >= QCNT_W'(QUEUE_DEPTH);
   assign accept   = req_push && !req_full;

   mmld_front #(.MAX_POINTS(MAX_POINTS)) u_front (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (accept),
      .sample_i    (req_sample_i),
      .sample_q    (req_sample_q),
      .last_sample (req_last_sample),
      .pairs       (pairs_ff),
      .out_valid   (front_valid),
      .out_item    (front_item),
      .inflight    (front_inflight)
   );

   mmld_queue #(.WIDTH(MID_W)) u_mid_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (front_valid),
      .push_data (front_item),
      .pop       (back_take),
      .pop_data  (mid_item),
      .status    (mid_status)
   );

   // back credit: results in flight plus those waiting for the receiver
   assign back_take = !mid_status.empty &&
      ((QCNT_W'(back_inflight) + out_status.count) < QCNT_W'(QUEUE_DEPTH));

   mmld_back #(.MAX_POINTS(MAX_POINTS), .MAX_BITS(MAX_BITS)) u_back (
      .clock           (clock),
      .reset           (reset),
      .in_valid        (back_take),
      .in_item         (mid_item),
      .bits_per_symbol (bps_ff),
      .inv_noise       (inv_ff),
      .out_valid       (back_valid),
      .out_item        (back_item),
      .inflight        (back_inflight)
   );

   mmld_queue #(.WIDTH(OUT_W)) u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (back_valid),
      .push_data (back_item),
      .pop       (rsp_pop),
      .pop_data  (out_item),
      .status    (out_status)
   );

   assign rsp_empty    = out_status.empty;
   assign rsp_llr_bit0 = out_item[LLR_W-1:0];
   assign rsp_llr_bit1 = out_item[2*LLR_W-1:LLR_W];
   assign rsp_llr_bit2 = out_item[3*LLR_W-1:2*LLR_W];
   assign rsp_last_llr = out_item[3*LLR_W];

   // credits keep both queues from overflowing
   a_mid_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(front_valid && mid_status.full && !back_take))
      else $error("middle queue overflow");

   a_out_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(back_valid && out_status.full && !rsp_pop))
      else $error("output queue overflow");

   a_accept_reaches_queue: assert property (@(posedge clock) disable iff (reset)
      accept |=> ##1 front_valid)
      else $error("accepted sample lost in front stages");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> rsp_empty)
      else $error("result visible right after reset");

endmodule
